FILE: hw/rtl/ssf_pkg.sv
package ssf_pkg;
  localparam int Order    = 4;
  localparam int CoefFrac = 13;
  localparam int DataW    = 16;
  localparam int AccW     = 40;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int TermsPerSum = Order + 1;
  localparam int NumSums  = Order + 1;

  localparam logic [CfgIdxW-1:0] RegRow0  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBd    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegC     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegD     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegStart = 3'd7;

  typedef struct packed {
    logic                    start;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic                    clear;
  } mac_req_t;

  function automatic logic signed [DataW-1:0] lane16(input logic [63:0] w,
                                                     input logic [1:0] i);
    lane16 = w[{i, 4'd0} +: DataW];
  endfunction

  function automatic logic signed [DataW-1:0] sat16(input logic signed [AccW-1:0] v,
                                                    output logic clip);
    logic signed [AccW-1:0] s;
    s = v >>> CoefFrac;
    clip = 1'b0;
    if (s > 40'sd32767) begin
      clip = 1'b1;
      sat16 = 16'sh7fff;
    end else if (s < -40'sd32768) begin
      clip = 1'b1;
      sat16 = 16'sh8000;
    end else begin
      sat16 = s[DataW-1:0];
    end
  endfunction
endpackage

FILE: hw/rtl/ssf_serial_mac.sv
// Shift-and-add multiply: one multiplier bit per cycle.
module ssf_serial_mac import ssf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mac_req_t               req_i,
  output logic                   busy_o,
  output logic signed [AccW-1:0] acc_o
);
  logic [4:0]             cnt_q, cnt_d;
  logic signed [AccW-1:0] mcand_q, mcand_d;
  logic [DataW-1:0]       mplier_q, mplier_d;
  logic signed [AccW-1:0] acc_q, acc_d;

  always_comb begin
    cnt_d = cnt_q;
    mcand_d = mcand_q;
    mplier_d = mplier_q;
    acc_d = acc_q;
    if (req_i.start) begin
      cnt_d = 5'd16;
      mcand_d = AccW'(req_i.a);
      mplier_d = req_i.b;
      if (req_i.clear) acc_d = '0;
    end else if (cnt_q != 5'd0) begin
      // top multiplier bit carries negative weight
      if (mplier_q[0]) begin
        if (cnt_q == 5'd1) acc_d = acc_q - mcand_q;
        else acc_d = acc_q + mcand_q;
      end
      mcand_d = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    mplier_q <= mplier_d;
    acc_q <= acc_d;
  end

  assign busy_o = (cnt_q != 5'd0);
  assign acc_o = acc_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_o) else $error("mac restarted while busy");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> cnt_q == 5'd16) else $error("mac length");
  a_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !req_i.start) |=> cnt_q == $past(cnt_q) - 5'd1) else $error("mac count");
endmodule

FILE: hw/rtl/state_space_filter_step.sv
// Channel  | Dir | Handshake        | Payload
// s_axis   | in  | tvalid/tready    | tdata: sample_in[15:0]; tuser: restart
// m_axis   | out | tvalid/tready    | tdata: sample_out[15:0]; tuser: clipped
// cfg      | in  | cfg_valid/ready  | cfg_index_i, cfg_data_i
// One sample takes 25 products through the one serial multiplier (each an
// issue, sixteen shift-add steps and a completion check), plus entry and
// writeback.
// The next sample is taken once the result is in the output register, even if
// it waits there. Reset clears state, coefficients and the output valid.
// A stalled output stops the next writeback until the beat is taken.
module state_space_filter_step import ssf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,  // sample_in
  input  logic                s_axis_tuser,  // restart
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // sample_out
  output logic                m_axis_tuser,  // clipped
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  typedef enum logic [1:0] {StIdle, StIssue, StWait, StDone} state_e;

  state_e                 state_q;
  logic [CfgDataW-1:0]    regs_q [8];
  logic signed [DataW-1:0] x_q [Order];
  logic signed [DataW-1:0] nx_q [Order];
  logic signed [DataW-1:0] u_q;
  logic signed [DataW-1:0] y_q;
  logic [2:0]             sum_q;   // 0 = output, 1..4 = states
  logic [2:0]             term_q;  // 0 = input term, 1..4 = state terms
  logic                   clip_q, go_q;
  mac_req_t               req;
  logic                   mac_busy;
  logic signed [AccW-1:0] acc;
  logic signed [DataW-1:0] coef, sat;
  logic                   sat_clip;
  logic [1:0]             ri, ci;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == StIdle) && !go_q;

  always_comb begin
    ri = 2'(sum_q - 3'd1);
    ci = 2'(term_q - 3'd1);
    if (sum_q == 3'd0) coef = (term_q == 3'd0) ? regs_q[RegD][15:0] : lane16(regs_q[RegC], ci);
    else if (term_q == 3'd0) coef = lane16(regs_q[RegBd], ri);
    else coef = lane16(regs_q[{1'b0, ri}], ci);
    req.start = (state_q == StIssue);
    req.a = coef;
    req.b = (term_q == 3'd0) ? u_q : x_q[ci];
    req.clear = (term_q == 3'd0);
    sat = sat16(acc, sat_clip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      go_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
      for (int i = 0; i < Order; i++) x_q[i] <= '0;
      sum_q <= '0;
      term_q <= '0;
      clip_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegD) regs_q[cfg_index_i] <= {48'd0, cfg_data_i[15:0]};
        else regs_q[cfg_index_i] <= cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready && state_q != StDone) m_axis_tvalid <= 1'b0;
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            u_q <= s_axis_tdata;
            if (s_axis_tuser)
              for (int i = 0; i < Order; i++) x_q[i] <= lane16(regs_q[RegStart], 2'(i));
            sum_q <= '0;
            term_q <= '0;
            clip_q <= 1'b0;
            state_q <= StIssue;
          end
        end
        StIssue: state_q <= StWait;
        StWait: begin
          if (!mac_busy) begin
            if (term_q != 3'(Order)) begin
              term_q <= term_q + 3'd1;
              state_q <= StIssue;
            end else begin
              if (sat_clip) clip_q <= 1'b1;
              // hold the output sum until the output register is free
              if (sum_q == 3'd0) y_q <= sat;
              else nx_q[ri] <= sat;
              term_q <= '0;
              if (sum_q == 3'(Order)) state_q <= StDone;
              else begin
                sum_q <= sum_q + 3'd1;
                state_q <= StIssue;
              end
            end
          end
        end
        StDone: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            for (int i = 0; i < Order; i++) x_q[i] <= nx_q[i];
            m_axis_tdata <= y_q;
            m_axis_tuser <= clip_q;
            m_axis_tvalid <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      go_q <= 1'b0;
    end
  end

  ssf_serial_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped");
  a_done_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && (!m_axis_tvalid || m_axis_tready)) |=> m_axis_tvalid)
    else $error("result lost");
endmodule
